/* sv/sialu_pkg.sv */
// Package: shared types and constants for the scalar 64-bit integer ALU.
`timescale 1ns / 1ps

package sialu_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned DEST_W  = 5;
  localparam int unsigned SIZE_W  = 2;
  localparam int unsigned SHAMT_W = $clog2(DATA_W);

  localparam logic [SIZE_W-1:0] LEGAL_SIZE = 2'b11;

  typedef enum logic [3:0] {
    MODE_ADD   = 4'd0,
    MODE_SUB   = 4'd1,
    MODE_EQ    = 4'd2,
    MODE_GE    = 4'd3,
    MODE_GT    = 4'd4,
    MODE_HI    = 4'd5,
    MODE_HS    = 4'd6,
    MODE_TST   = 4'd7,
    MODE_SSHL  = 4'd8,
    MODE_USHL  = 4'd9,
    MODE_EQZ   = 4'd10,
    MODE_GEZ   = 4'd11,
    MODE_GTZ   = 4'd12,
    MODE_LEZ   = 4'd13,
    MODE_LTZ   = 4'd14
  } alu_mode_t;

  typedef struct packed {
    alu_mode_t          mode;
    logic [SIZE_W-1:0]  size_code;
    logic [DATA_W-1:0]  operand_a;
    logic [DATA_W-1:0]  operand_b;
    logic [DEST_W-1:0]  dest_index;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]  result_value;
    logic [DEST_W-1:0]  result_dest;
    logic               illegal;
  } out_item_t;

endpackage

/* sv/sialu_shift.sv */
// Module: register-controlled shifter for SSHL and USHL.
`timescale 1ns / 1ps

module sialu_shift (
  input  logic [sialu_pkg::DATA_W-1:0] operand_a,
  input  logic [7:0]                   shift_byte,
  input  logic                         arith,
  output logic [sialu_pkg::DATA_W-1:0] shift_out
);
  import sialu_pkg::*;

  logic                     neg;
  logic [7:0]               mag;
  logic                     fill_bit;
  logic                     left_oor;
  logic                     right_oor;
  logic [DATA_W-1:0]        shl;
  logic signed [DATA_W:0]   ext_s;
  logic [DATA_W:0]          shr;

  assign neg      = shift_byte[7];
  // Two's complement magnitude of a negative amount: 1..128.
  assign mag      = 8'(~shift_byte + 8'd1);
  assign fill_bit = arith & operand_a[DATA_W-1];

  assign left_oor  = (shift_byte >= 8'(DATA_W));
  assign right_oor = (mag >= 8'(DATA_W));

  assign shl   = operand_a << shift_byte[SHAMT_W-1:0];
  assign ext_s = {fill_bit, operand_a};
  assign shr   = ext_s >>> mag[SHAMT_W-1:0];

  always_comb begin
    if (!neg) begin
      shift_out = left_oor ? '0 : shl;
    end else begin
      shift_out = right_oor ? {DATA_W{fill_bit}} : shr[DATA_W-1:0];
    end
  end

endmodule

/* sv/sialu_exec.sv */
// Module: combinational execute logic for one ALU operation.
`timescale 1ns / 1ps

module sialu_exec (
  input  sialu_pkg::in_item_t  item,
  output sialu_pkg::out_item_t result
);
  import sialu_pkg::*;

  logic [DATA_W-1:0] a;
  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] sum;
  logic [DATA_W-1:0] diff;
  logic [DATA_W:0]   cmp;
  logic              eq;
  logic              hs;
  logic              hi;
  logic              ge;
  logic              gt;
  logic              a_zero;
  logic              a_neg;
  logic              tst;
  logic [DATA_W-1:0] shift_out;
  logic              bad;
  logic [DATA_W-1:0] value;

  assign a = item.operand_a;
  assign b = item.operand_b;

  assign sum  = a + b;
  assign diff = a - b;
  // Borrow out of the wide subtract marks a < b unsigned.
  assign cmp  = {1'b0, a} - {1'b0, b};

  assign eq     = (a == b);
  assign hs     = ~cmp[DATA_W];
  assign hi     = hs & ~eq;
  assign ge     = (a[DATA_W-1] == b[DATA_W-1]) ? hs : b[DATA_W-1];
  assign gt     = ge & ~eq;
  assign a_zero = (a == '0);
  assign a_neg  = a[DATA_W-1];
  assign tst    = |(a & b);

  sialu_shift u_shift (
    .operand_a  (a),
    .shift_byte (b[7:0]),
    .arith      (item.mode == MODE_SSHL),
    .shift_out  (shift_out)
  );

  always_comb begin
    bad   = (item.size_code != LEGAL_SIZE);
    value = '0;
    unique case (item.mode)
      MODE_ADD:  value = sum;
      MODE_SUB:  value = diff;
      MODE_EQ:   value = {DATA_W{eq}};
      MODE_GE:   value = {DATA_W{ge}};
      MODE_GT:   value = {DATA_W{gt}};
      MODE_HI:   value = {DATA_W{hi}};
      MODE_HS:   value = {DATA_W{hs}};
      MODE_TST:  value = {DATA_W{tst}};
      MODE_SSHL: value = shift_out;
      MODE_USHL: value = shift_out;
      MODE_EQZ:  value = {DATA_W{a_zero}};
      MODE_GEZ:  value = {DATA_W{~a_neg}};
      MODE_GTZ:  value = {DATA_W{~a_neg & ~a_zero}};
      MODE_LEZ:  value = {DATA_W{a_neg | a_zero}};
      MODE_LTZ:  value = {DATA_W{a_neg}};
      default:   bad   = 1'b1;
    endcase
    result.result_value = bad ? '0 : value;
    result.result_dest  = item.dest_index;
    result.illegal      = bad;
  end

endmodule

/* sv/scalar_int64_simd_alu_core.sv */
// Top level: scalar 64-bit three-same integer ALU with input and result registers.
`timescale 1ns / 1ps

// Channel   Ports                        Beat taken when
// --------  ---------------------------  ------------------------------
// input     start, busy, in_item         rising edge with start && !busy
// result    out_valid, out_item          rising edge ending out_valid cycle
//
// Each beat passes two registers from start to out_valid: first the input
// register, then the execute logic (a 64-bit add/compare or the barrel
// shifter) settles into the result register.
// A new beat may enter on every cycle; busy stays low.
// Reset (rst_n low, synchronous) clears both valid flags; payload registers
// are not reset.
// The receiver cannot stall: each result shows for exactly one cycle.

module scalar_int64_simd_alu_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  sialu_pkg::in_item_t  in_item,
  output logic                 out_valid,
  output sialu_pkg::out_item_t out_item
);
  import sialu_pkg::*;

  logic      in_valid_r;
  logic      in_valid_nxt;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t exec_result;

  // Every cycle is open for a new beat.
  assign busy         = 1'b0;
  assign in_valid_nxt = start & ~busy;

  // Hold the accepted operands for the execute cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_nxt) begin
      in_item_r <= in_item;
    end
  end

  sialu_exec u_exec (
    .item   (in_item_r),
    .result (exec_result)
  );

  // Advance the result into the output register; it shows for one cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      out_item_r <= exec_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* sv/sialu_chk.sv */
// Checker: port-level assertions for the scalar ALU, bound to the top level.
`timescale 1ns / 1ps

module sialu_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input sialu_pkg::in_item_t  in_item,
  input logic                 out_valid,
  input sialu_pkg::out_item_t out_item
);
  import sialu_pkg::*;

  // Every accepted beat yields a result through the input and result registers.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("accepted beat produced no result");

  // No result without an accepted beat ahead of it in the input and result registers.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without an accepted beat");

  // Destination passes through unchanged.
  a_dest_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.result_dest == $past(in_item.dest_index, 2)))
    else $error("result_dest does not match dest_index");

  // Illegal encodings write zero.
  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.illegal) |-> (out_item.result_value == '0))
    else $error("illegal result is not zero");

  // Reserved size always flags illegal.
  a_size_illegal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_item.size_code, 2) != LEGAL_SIZE)) |-> out_item.illegal)
    else $error("reserved size not flagged");

endmodule

bind scalar_int64_simd_alu_core sialu_chk u_sialu_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

/* verif/testbench.sv */
// Testbench: scalar 64-bit integer ALU, directed table then random beats.
`timescale 1ns / 1ps

module testbench;
  import sialu_pkg::*;

  localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};
  localparam logic [DATA_W-1:0] SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] MAX_POS  = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [3:0] MODE_UNUSED = 4'hF;
  // Reserved size codes: byte, half and word forms are not implemented.
  localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
  localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
  localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BEATS = 1025;
  localparam int PRINT_CAP = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  // One directed row: the beat to send, and a literal answer where it is obvious.
  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } alu_row_t;

  alu_row_t  directed_plan[$];
  out_item_t pending_results[$];
  out_item_t oldest_result;
  int        mismatch_count = 0;
  int        cycle_count = 0;

  scalar_int64_simd_alu_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #6 clk = ~clk;

  // Watchdog: stop a hung run long after the slowest correct one would end.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[scalar_int64_simd_alu_core] ERROR");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
  endtask

  function automatic logic [DATA_W-1:0] mask_of(input bit cond);
    return cond ? ALL_ONES : '0;
  endfunction

  // Register-controlled shift: signed low byte of b, positive left, negative right.
  function automatic logic [DATA_W-1:0] shift_by_byte(input logic [DATA_W-1:0] a,
                                                      input logic [7:0] amt_byte,
                                                      input bit arith);
    logic [8:0]        mag;
    logic [DATA_W-1:0] fill;
    fill = (arith && a[DATA_W-1]) ? ALL_ONES : '0;
    if (!amt_byte[7])
      return (amt_byte >= DATA_W) ? '0 : (a << amt_byte);
    mag = 9'd256 - {1'b0, amt_byte};
    if (mag >= DATA_W)
      return fill;
    if (arith)
      return $signed(a) >>> mag[5:0];
    return a >> mag[5:0];
  endfunction

  // Expected result of one beat: operation, destination pass-through, illegal flag.
  function automatic out_item_t compute_alu_result(input in_item_t item);
    out_item_t         res;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    a = item.operand_a;
    b = item.operand_b;
    res.result_dest  = item.dest_index;
    res.result_value = '0;
    res.illegal      = (item.size_code != LEGAL_SIZE) || (4'(item.mode) == MODE_UNUSED);
    if (!res.illegal) begin
      case (item.mode)
        MODE_ADD:  res.result_value = a + b;
        MODE_SUB:  res.result_value = a - b;
        MODE_EQ:   res.result_value = mask_of(a == b);
        MODE_GE:   res.result_value = mask_of($signed(a) >= $signed(b));
        MODE_GT:   res.result_value = mask_of($signed(a) > $signed(b));
        MODE_HI:   res.result_value = mask_of(a > b);
        MODE_HS:   res.result_value = mask_of(a >= b);
        MODE_TST:  res.result_value = mask_of((a & b) != '0);
        MODE_SSHL: res.result_value = shift_by_byte(a, b[7:0], 1'b1);
        MODE_USHL: res.result_value = shift_by_byte(a, b[7:0], 1'b0);
        MODE_EQZ:  res.result_value = mask_of(a == '0);
        MODE_GEZ:  res.result_value = mask_of(!a[DATA_W-1]);
        MODE_GTZ:  res.result_value = mask_of(!a[DATA_W-1] && a != '0);
        MODE_LEZ:  res.result_value = mask_of(a[DATA_W-1] || a == '0);
        default:   res.result_value = mask_of(a[DATA_W-1]);
      endcase
    end
    return res;
  endfunction

  // Append a directed row; the row index doubles as destination so its bits move.
  function automatic void add_row(input alu_mode_t mode, input logic [SIZE_W-1:0] size,
                                  input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
                                  input bit typed, input logic [DATA_W-1:0] value,
                                  input logic ill);
    alu_row_t row;
    row.stim.mode         = mode;
    row.stim.size_code    = size;
    row.stim.operand_a    = a;
    row.stim.operand_b    = b;
    row.stim.dest_index   = DEST_W'(directed_plan.size());
    row.typed             = typed;
    row.want.result_value = value;
    row.want.result_dest  = row.stim.dest_index;
    row.want.illegal      = ill;
    directed_plan.push_back(row);
  endfunction

  function automatic logic [DATA_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Bias operands toward the edges of both signed and unsigned ranges.
  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return ALL_ONES;
      2:       return SIGN_BIT;
      3:       return MAX_POS;
      4:       return DATA_W'($urandom_range(1, 3));
      5:       return SIGN_BIT | DATA_W'($urandom_range(0, 3));
      default: return random_word();
    endcase
  endfunction

  function automatic in_item_t make_random_beat();
    in_item_t          item;
    logic [7:0]        amt_byte;
    logic [DATA_W-1:0] upper_word;
    item.mode       = alu_mode_t'($urandom_range(0, 14));
    item.size_code  = ($urandom_range(0, 99) < 6) ? SIZE_W'($urandom_range(0, 2)) : LEGAL_SIZE;
    item.operand_a  = pick_operand();
    item.operand_b  = pick_operand();
    item.dest_index = DEST_W'($urandom_range(0, 31));
    if ($urandom_range(0, 199) == 0)
      item.mode = alu_mode_t'(MODE_UNUSED);
    // Compares: land on equality and its neighbors often.
    if (item.mode inside {MODE_EQ, MODE_GE, MODE_GT, MODE_HI, MODE_HS}) begin
      case ($urandom_range(0, 9))
        0, 1, 2: item.operand_b = item.operand_a;
        3:       item.operand_b = item.operand_a + 1;
        4:       item.operand_b = item.operand_a - 1;
        default: ;
      endcase
    end
    // Shifts: keep upper bits of b random, steer the amount byte to the boundaries.
    if (item.mode inside {MODE_SSHL, MODE_USHL}) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: amt_byte = 8'($urandom_range(0, 255));
        4, 5, 6:    amt_byte = 8'($urandom_range(56, 72));
        7, 8:       amt_byte = 8'($urandom_range(184, 200));
        default:    amt_byte = 8'($urandom_range(124, 132));
      endcase
      upper_word     = random_word();
      item.operand_b = {upper_word[DATA_W-1:8], amt_byte};
    end
    return item;
  endfunction

  // Present one beat and hold it until taken; log its expected result at that edge.
  task automatic issue_beat(input in_item_t item, input out_item_t want);
    start   <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(want);
  endtask

  // Drop start for a gap whose length is set by n; a zero gap leaves start alone.
  task automatic hold_off(input int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drop start and wait until every pending result has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Result side: a strobed beat is taken at the edge that ends its cycle;
  // compare it against the oldest pending expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result", out_item.result_value, '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_item.result_value !== oldest_result.result_value)
          note_mismatch("result_value", out_item.result_value, oldest_result.result_value);
        if (out_item.result_dest !== oldest_result.result_dest)
          note_mismatch("result_dest", DATA_W'(out_item.result_dest),
                        DATA_W'(oldest_result.result_dest));
        if (out_item.illegal !== oldest_result.illegal)
          note_mismatch("illegal", DATA_W'(out_item.illegal), DATA_W'(oldest_result.illegal));
      end
    end
  end

  initial begin
    int        burst_left;
    int        gap;
    in_item_t  item;
    alu_row_t  row;

    // Directed table: wrap, each compare sense, shift boundaries, zero forms,
    // reserved sizes and the unused mode encoding.
    add_row(MODE_ADD,  LEGAL_SIZE, ALL_ONES, 64'd1, 1, '0, 1'b0);
    add_row(MODE_ADD,  LEGAL_SIZE, SIGN_BIT, SIGN_BIT, 1, '0, 1'b0);
    add_row(MODE_SUB,  LEGAL_SIZE, '0, 64'd1, 1, ALL_ONES, 1'b0);
    add_row(MODE_SUB,  LEGAL_SIZE, SIGN_BIT, MAX_POS, 0, '0, 1'b0);
    add_row(MODE_EQ,   LEGAL_SIZE, ALL_ONES, ALL_ONES, 1, ALL_ONES, 1'b0);
    add_row(MODE_GE,   LEGAL_SIZE, ALL_ONES, '0, 1, '0, 1'b0);
    add_row(MODE_GT,   LEGAL_SIZE, MAX_POS, SIGN_BIT, 1, ALL_ONES, 1'b0);
    add_row(MODE_HI,   LEGAL_SIZE, SIGN_BIT, MAX_POS, 1, ALL_ONES, 1'b0);
    add_row(MODE_HS,   LEGAL_SIZE, MAX_POS, MAX_POS, 1, ALL_ONES, 1'b0);
    add_row(MODE_TST,  LEGAL_SIZE, 64'hF0, 64'h0F, 1, '0, 1'b0);
    add_row(MODE_TST,  LEGAL_SIZE, SIGN_BIT, ALL_ONES, 0, '0, 1'b0);
    add_row(MODE_SSHL, LEGAL_SIZE, ALL_ONES, 64'd64, 1, '0, 1'b0);
    add_row(MODE_SSHL, LEGAL_SIZE, SIGN_BIT, 64'hC0, 1, ALL_ONES, 1'b0);
    add_row(MODE_SSHL, LEGAL_SIZE, SIGN_BIT, 64'hFF, 1, 64'hC000_0000_0000_0000, 1'b0);
    add_row(MODE_SSHL, LEGAL_SIZE, 64'hDEAD_BEEF_0123_4567, 64'hFFFF_FFFF_FFFF_FFC1,
            0, '0, 1'b0);
    add_row(MODE_USHL, LEGAL_SIZE, ALL_ONES, 64'h80, 1, '0, 1'b0);
    add_row(MODE_USHL, LEGAL_SIZE, ALL_ONES, 64'h7F, 1, '0, 1'b0);
    add_row(MODE_USHL, LEGAL_SIZE, 64'd1, 64'h3F, 1, SIGN_BIT, 1'b0);
    add_row(MODE_EQZ,  LEGAL_SIZE, '0, ALL_ONES, 1, ALL_ONES, 1'b0);
    add_row(MODE_GEZ,  LEGAL_SIZE, '0, ALL_ONES, 1, ALL_ONES, 1'b0);
    add_row(MODE_GTZ,  LEGAL_SIZE, '0, ALL_ONES, 1, '0, 1'b0);
    add_row(MODE_LEZ,  LEGAL_SIZE, SIGN_BIT, '0, 1, ALL_ONES, 1'b0);
    add_row(MODE_LTZ,  LEGAL_SIZE, MAX_POS, '0, 1, '0, 1'b0);
    add_row(MODE_ADD,  SIZE_BYTE, ALL_ONES, ALL_ONES, 1, '0, 1'b1);
    add_row(MODE_SUB,  SIZE_HALF, ALL_ONES, 64'd1, 1, '0, 1'b1);
    add_row(MODE_EQ,   SIZE_WORD, '0, '0, 1, '0, 1'b1);
    add_row(alu_mode_t'(MODE_UNUSED), LEGAL_SIZE, ALL_ONES, ALL_ONES, 1, '0, 1'b1);

    // Hold reset, then release it once.
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the table back to back; rows without a literal use the predictor.
    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      issue_beat(row.stim, row.typed ? row.want : compute_alu_result(row.stim));
    end
    drain_results();

    // Random part: bursts of random length, separated by random gaps,
    // with some long bursts that never idle.
    burst_left = 0;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 2) begin
        drain_results();
      end
      if (burst_left == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          burst_left = $urandom_range(40, 100);
          gap = 0;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
        end
        hold_off(gap);
      end
      burst_left--;
      item = make_random_beat();
      issue_beat(item, compute_alu_result(item));
    end

    // Let the pipeline empty, then idle on to catch stray strobes.
    drain_results();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0)
      note_mismatch("results never returned", DATA_W'(pending_results.size()), '0);

    if (mismatch_count == 0)
      $display("[scalar_int64_simd_alu_core] OK");
    else
      $display("[scalar_int64_simd_alu_core] ERROR");
    $finish;
  end

endmodule

/* files.f */
sv/sialu_pkg.sv
sv/sialu_shift.sv
sv/sialu_exec.sv
sv/scalar_int64_simd_alu_core.sv
sv/sialu_chk.sv
verif/testbench.sv
